// File: hdl/mcpf_pkg.sv
// ----------------------------------------------------------------------------
// mcpf_pkg - shared types and constants of the masked correlation peak finder
// Register codes, field widths, mask arithmetic constants and the frame
// geometry bundle handed from the configuration block to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mcpf_pkg;

    // field widths
    localparam int DIM_W    = 13;   // frame_cols / frame_rows and derived bounds
    localparam int HALF_W   = 12;   // half extent (centre)
    localparam int BANDS_W  = 4;
    localparam int PCT_W    = 7;
    localparam int SAMPLE_W = 16;
    localparam int OFF_W    = 12;
    localparam int CIDX_W   = 2;

    // largest frame dimension and band count the register fields can carry
    localparam int DIM_FIELD_MAX  = (1 << DIM_W) - 1;
    localparam int BAND_FIELD_MAX = (1 << BANDS_W) - 1;

    // mask arithmetic: centre * percent, then divide by 100 via reciprocal
    localparam int PROD_W      = HALF_W + PCT_W;
    localparam int RECIP_W     = 20;
    localparam int RECIP_SHIFT = 26;
    localparam logic [RECIP_W-1:0] PCT_RECIP = 20'd671089;   // ceil(2^26 / 100)
    localparam logic [PCT_W-1:0]   PCT_MAX   = 7'd99;
    localparam logic [PCT_W-1:0]   PCT_MIN   = 7'd1;
    localparam logic [PROD_W-1:0]  PCT_DIV   = 19'd100;

    // cycles from a register write until the mask bounds are valid
    localparam int SETTLE_W = 2;
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    // register reset values
    localparam logic [DIM_W-1:0]   RST_FRAME_COLS   = 13'd4096;
    localparam logic [DIM_W-1:0]   RST_FRAME_ROWS   = 13'd4096;
    localparam logic [BANDS_W-1:0] RST_BAND_COUNT   = 4'd1;
    localparam logic [PCT_W-1:0]   RST_MASK_PERCENT = 7'd0;

    typedef enum logic [CIDX_W-1:0] {
        CFG_FRAME_COLS   = 2'd0,
        CFG_FRAME_ROWS   = 2'd1,
        CFG_BAND_COUNT   = 2'd2,
        CFG_MASK_PERCENT = 2'd3
    } t_cfg_idx;

    // clamped geometry and mask rectangle, all bounds exclusive at the top
    typedef struct packed {
        logic               settled;
        logic [DIM_W-1:0]   cols;
        logic [DIM_W-1:0]   rows;
        logic [BANDS_W-1:0] bands;
        logic [HALF_W-1:0]  pc;
        logic [HALF_W-1:0]  pr;
        logic [DIM_W-1:0]   cmin;
        logic [DIM_W-1:0]   cmax;
        logic [DIM_W-1:0]   rmin;
        logic [DIM_W-1:0]   rmax;
    } t_geom;

    function automatic int dim_limit(input int max_dim);
        return (max_dim > DIM_FIELD_MAX) ? DIM_FIELD_MAX : max_dim;
    endfunction

    function automatic int band_limit(input int max_bands);
        return (max_bands > BAND_FIELD_MAX) ? BAND_FIELD_MAX : max_bands;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mcpf_geom.sv
// ----------------------------------------------------------------------------
// mcpf_geom - configuration registers and mask rectangle
// Holds the four registers, clamps them and derives the mask bounds in a
// short pipeline; reports settled once the bounds match the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpf_geom
    import mcpf_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_BANDS = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CIDX_W-1:0]  i_cfg_index,
    input  wire logic [DIM_W-1:0]   i_cfg_data,
    output t_geom                   o_geom
);

    localparam int DIM_CLIP  = dim_limit(MAX_DIM);
    localparam int BAND_CLIP = band_limit(MAX_BANDS);

    logic [DIM_W-1:0]    r_frame_cols, r_frame_rows;
    logic [BANDS_W-1:0]  r_band_count;
    logic [PCT_W-1:0]    r_mask_percent;
    logic [SETTLE_W-1:0] r_settle_cnt;

    logic [DIM_W-1:0]    cols, rows;
    logic [BANDS_W-1:0]  bands;
    logic [PCT_W-1:0]    pct;
    logic [HALF_W-1:0]   pc, pr;

    logic [PROD_W-1:0]   r_cpx, r_rpx;
    logic [HALF_W-1:0]   r_cfq, r_rfq;
    logic [DIM_W-1:0]    r_cmin, r_cmax, r_rmin, r_rmax;

    logic [PROD_W+RECIP_W-1:0] cq_full, rq_full;
    logic [HALF_W-1:0]         cq_ceil, rq_ceil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_cols   <= RST_FRAME_COLS;
            r_frame_rows   <= RST_FRAME_ROWS;
            r_band_count   <= RST_BAND_COUNT;
            r_mask_percent <= RST_MASK_PERCENT;
            r_settle_cnt   <= SETTLE_CYCLES;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FRAME_COLS:   r_frame_cols   <= i_cfg_data;
                    CFG_FRAME_ROWS:   r_frame_rows   <= i_cfg_data;
                    CFG_BAND_COUNT:   r_band_count   <= i_cfg_data[BANDS_W-1:0];
                    CFG_MASK_PERCENT: r_mask_percent <= i_cfg_data[PCT_W-1:0];
                endcase
                r_settle_cnt <= SETTLE_CYCLES;
            end else if (r_settle_cnt != '0) begin
                r_settle_cnt <= r_settle_cnt - 1'b1;
            end
        end
    end

    // clamps
    always_comb begin
        if (r_frame_cols == '0)              cols = DIM_W'(1);
        else if (32'(r_frame_cols) > DIM_CLIP) cols = DIM_W'(DIM_CLIP);
        else                                 cols = r_frame_cols;

        if (r_frame_rows == '0)              rows = DIM_W'(1);
        else if (32'(r_frame_rows) > DIM_CLIP) rows = DIM_W'(DIM_CLIP);
        else                                 rows = r_frame_rows;

        if (r_band_count == '0)                bands = BANDS_W'(1);
        else if (32'(r_band_count) > BAND_CLIP) bands = BANDS_W'(BAND_CLIP);
        else                                   bands = r_band_count;

        if (r_mask_percent > PCT_MAX)       pct = PCT_MAX;
        else if (r_mask_percent <= PCT_MIN) pct = '0;
        else                                pct = r_mask_percent;
    end

    assign pc = cols[DIM_W-1:1];
    assign pr = rows[DIM_W-1:1];

    assign cq_full = (PROD_W+RECIP_W)'(r_cpx) * (PROD_W+RECIP_W)'(PCT_RECIP);
    assign rq_full = (PROD_W+RECIP_W)'(r_rpx) * (PROD_W+RECIP_W)'(PCT_RECIP);

    // ceiling: add one where the division left a remainder
    assign cq_ceil = r_cfq + HALF_W'(PROD_W'(r_cfq) * PCT_DIV != r_cpx);
    assign rq_ceil = r_rfq + HALF_W'(PROD_W'(r_rfq) * PCT_DIV != r_rpx);

    // bound pipeline: product, quotient, bounds
    always_ff @(posedge i_clk) begin
        r_cpx  <= PROD_W'(pc) * PROD_W'(pct);
        r_rpx  <= PROD_W'(pr) * PROD_W'(pct);
        r_cfq  <= cq_full[RECIP_SHIFT +: HALF_W];
        r_rfq  <= rq_full[RECIP_SHIFT +: HALF_W];
        r_cmin <= DIM_W'(pc) - DIM_W'(cq_ceil);
        r_cmax <= DIM_W'(pc) + DIM_W'(r_cfq);
        r_rmin <= DIM_W'(pr) - DIM_W'(rq_ceil);
        r_rmax <= DIM_W'(pr) + DIM_W'(r_rfq);
    end

    always_comb begin
        o_geom.settled = (r_settle_cnt == '0);
        o_geom.cols    = cols;
        o_geom.rows    = rows;
        o_geom.bands   = bands;
        o_geom.pc      = pc;
        o_geom.pr      = pr;
        o_geom.cmin    = r_cmin;
        o_geom.cmax    = r_cmax;
        o_geom.rmin    = r_rmin;
        o_geom.rmax    = r_rmax;
    end

endmodule

`default_nettype wire

// File: hdl/mcpf_core.sv
// ----------------------------------------------------------------------------
// mcpf_core - band product, masked peak search and result register
// Input register, combinational compute of the composite and running maximum,
// and a result register that holds the frame result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpf_core
    import mcpf_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_BANDS = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  t_geom                           i_geom,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [SAMPLE_W-1:0]        i_sample,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [SAMPLE_W-1:0]             o_peak_value,
    output logic signed [OFF_W-1:0]         o_offset_x,
    output logic signed [OFF_W-1:0]         o_offset_y,
    output logic                            o_peak_found
);

    localparam int DIM_CLIP  = dim_limit(MAX_DIM);
    localparam int BAND_CLIP = band_limit(MAX_BANDS);
    localparam int IDX_W     = $clog2(DIM_CLIP);
    localparam int BAND_W    = (BAND_CLIP > 1) ? $clog2(BAND_CLIP) : 1;

    logic                 r_s1_valid;
    logic [SAMPLE_W-1:0]  r_s1_sample;

    logic [BAND_W-1:0]    r_band;
    logic [IDX_W-1:0]     r_col, r_row;
    logic [SAMPLE_W-1:0]  r_run;
    logic [SAMPLE_W-1:0]  r_best;
    logic [IDX_W-1:0]     r_best_col, r_best_row;
    logic                 r_have;

    logic                 r_out_valid;
    logic [SAMPLE_W-1:0]  r_out_value;
    logic [OFF_W-1:0]     r_out_x, r_out_y;
    logic                 r_out_found;

    logic [BANDS_W:0]     band_nxt;
    logic [DIM_W:0]       col_nxt, row_nxt;
    logic                 band_last, col_last, row_last, frame_end;
    logic [2*SAMPLE_W-1:0] prod_full;
    logic [SAMPLE_W-1:0]  prod;
    logic [DIM_W-1:0]     col_ext, row_ext;
    logic                 in_area, masked, better;
    logic [SAMPLE_W-1:0]  n_best;
    logic [IDX_W-1:0]     n_best_col, n_best_row;
    logic                 n_have;
    logic [DIM_W-1:0]     off_x, off_y;
    logic                 consume;

    assign band_nxt  = (BANDS_W+1)'(r_band) + 1'b1;
    assign col_nxt   = (DIM_W+1)'(r_col) + 1'b1;
    assign row_nxt   = (DIM_W+1)'(r_row) + 1'b1;
    assign band_last = band_nxt >= (BANDS_W+1)'(i_geom.bands);
    assign col_last  = col_nxt >= (DIM_W+1)'(i_geom.cols);
    assign row_last  = row_nxt >= (DIM_W+1)'(i_geom.rows);
    assign frame_end = band_last && col_last && row_last;

    // composite: first band loads, later bands multiply keeping the high half
    assign prod_full = r_run * r_s1_sample;
    assign prod      = (r_band == '0) ? r_s1_sample : prod_full[2*SAMPLE_W-1:SAMPLE_W];

    assign col_ext = DIM_W'(r_col);
    assign row_ext = DIM_W'(r_row);
    assign in_area = (col_ext < {i_geom.cols[DIM_W-1:1], 1'b0})
                  && (row_ext < {i_geom.rows[DIM_W-1:1], 1'b0});
    assign masked  = (row_ext >= i_geom.rmin) && (row_ext < i_geom.rmax)
                  && (col_ext >= i_geom.cmin) && (col_ext < i_geom.cmax);
    assign better  = in_area && !masked && (!r_have || prod > r_best);

    assign n_best     = better ? prod  : r_best;
    assign n_best_col = better ? r_col : r_best_col;
    assign n_best_row = better ? r_row : r_best_row;
    assign n_have     = r_have || better;

    assign off_x = DIM_W'(n_best_col) - DIM_W'(i_geom.pc);
    assign off_y = DIM_W'(n_best_row) - DIM_W'(i_geom.pr);

    // a frame-ending item waits only while the result register is occupied
    assign consume = r_s1_valid && !(frame_end && r_out_valid && !i_ready);
    assign o_ready = i_geom.settled && (!r_s1_valid || consume);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_band      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_best      <= '0;
            r_best_col  <= '0;
            r_best_row  <= '0;
            r_have      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end else if (consume) begin
                r_s1_valid <= 1'b0;
            end

            // a result taken while the next one is published stays valid
            if (r_out_valid && i_ready && !(consume && frame_end)) begin
                r_out_valid <= 1'b0;
            end

            if (consume) begin
                if (!band_last) begin
                    r_band <= r_band + 1'b1;
                end else begin
                    r_band <= '0;
                    if (!col_last) begin
                        r_col      <= r_col + 1'b1;
                        r_best     <= n_best;
                        r_best_col <= n_best_col;
                        r_best_row <= n_best_row;
                        r_have     <= n_have;
                    end else if (!row_last) begin
                        r_col      <= '0;
                        r_row      <= r_row + 1'b1;
                        r_best     <= n_best;
                        r_best_col <= n_best_col;
                        r_best_row <= n_best_row;
                        r_have     <= n_have;
                    end else begin
                        // frame done: publish and clear the search state
                        r_col       <= '0;
                        r_row       <= '0;
                        r_best      <= '0;
                        r_best_col  <= '0;
                        r_best_row  <= '0;
                        r_have      <= 1'b0;
                        r_out_valid <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_sample <= i_sample;
        end
        if (consume) begin
            r_run <= prod;
        end
        if (consume && frame_end) begin
            r_out_value <= n_have ? n_best : '0;
            r_out_x     <= off_x[OFF_W-1:0];
            r_out_y     <= off_y[OFF_W-1:0];
            r_out_found <= n_have;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_peak_value = r_out_value;
    assign o_offset_x   = $signed(r_out_x);
    assign o_offset_y   = $signed(r_out_y);
    assign o_peak_found = r_out_found;

endmodule

`default_nettype wire

// File: hdl/masked_correlation_peak_finder_unit.sv
// ----------------------------------------------------------------------------
// masked_correlation_peak_finder_unit - masked peak search over a surface
// Multiplies the band samples of each pixel into a Q0.16 composite and keeps
// the first strict maximum outside a central mask; one result per frame.
// ----------------------------------------------------------------------------
// usage
//   input channel  : i_valid / o_ready carry one band sample per request,
//                    pixels in raster order with their bands interleaved
//   result channel : o_valid / i_ready carry one request per frame: peak
//                    value, offset from the centre and a found flag
//   config channel : i_cfg_valid / o_cfg_ready write one register per
//                    request (0 cols, 1 rows, 2 bands, 3 mask percent);
//                    o_cfg_ready is always high
// throughput: one sample per cycle outside the config and stall waits below,
//   set by the combinational band multiply and compare between the input
//   register and the search state
// result: o_valid rises when a frame's last sample reaches the result register
// config: after reset and after every register write o_ready stays low
//   while the mask bounds (centre * percent / 100) are rebuilt
// reset: synchronous, active low; registers return to 4096 x 4096, one band,
//   no mask, and the search state is cleared
// stall: while a result waits, samples keep flowing until the last sample of
//   the next frame, which is held in the input register until the result
//   register frees
// ----------------------------------------------------------------------------
`default_nettype none

module masked_correlation_peak_finder_unit
    import mcpf_pkg::*;
#(
    parameter int MAX_DIM   = 4096,
    parameter int MAX_BANDS = 8
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // sample requests
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [SAMPLE_W-1:0]    i_sample,
    // result requests
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [SAMPLE_W-1:0]         o_peak_value,
    output logic signed [OFF_W-1:0]     o_offset_x,
    output logic signed [OFF_W-1:0]     o_offset_y,
    output logic                        o_peak_found,
    // register writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CIDX_W-1:0]      i_cfg_index,
    input  wire logic [DIM_W-1:0]       i_cfg_data
);

    t_geom geom;

    // writes are never back-pressured
    assign o_cfg_ready = 1'b1;

    // register file and mask rectangle
    mcpf_geom #(
        .MAX_DIM   (MAX_DIM),
        .MAX_BANDS (MAX_BANDS)
    ) u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_geom      (geom)
    );

    // product, peak search and result holding
    mcpf_core #(
        .MAX_DIM   (MAX_DIM),
        .MAX_BANDS (MAX_BANDS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (geom),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_peak_value (o_peak_value),
        .o_offset_x   (o_offset_x),
        .o_offset_y   (o_offset_y),
        .o_peak_found (o_peak_found)
    );

endmodule

`default_nettype wire

// File: hdl/mcpf_checker.sv
// ----------------------------------------------------------------------------
// mcpf_checker - port-level checks of the peak finder
// Watches the top-level ports for request holding, empty result, reset and settle rules.
// ----------------------------------------------------------------------------
`default_nettype none

module mcpf_checker
    import mcpf_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                o_ready,
    input wire logic [SAMPLE_W-1:0] i_sample,
    input wire logic                o_valid,
    input wire logic                i_ready,
    input wire logic [SAMPLE_W-1:0] o_peak_value,
    input wire logic [OFF_W-1:0]    o_offset_x,
    input wire logic [OFF_W-1:0]    o_offset_y,
    input wire logic                o_peak_found,
    input wire logic                i_cfg_valid,
    input wire logic                o_cfg_ready
);

    // a waiting sample request holds
    a_input_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_sample))
        else $error("sample request dropped or changed while waiting");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_peak_value)
            && $stable(o_offset_x) && $stable(o_offset_y) && $stable(o_peak_found))
        else $error("result changed while stalled");

    // no peak means a zero peak value
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_peak_found |-> o_peak_value == '0)
        else $error("peak value set without a peak");

    // nothing shown and nothing taken straight after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid && !o_ready)
        else $error("activity right after reset");

    // bounds rebuild after a register write
    a_cfg_settle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> !o_ready)
        else $error("sample taken before mask bounds settled");

endmodule

bind masked_correlation_peak_finder_unit mcpf_checker u_mcpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_ready      (o_ready),
    .i_sample     (i_sample),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_peak_value (o_peak_value),
    .o_offset_x   (o_offset_x),
    .o_offset_y   (o_offset_y),
    .o_peak_found (o_peak_found),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready)
);

`default_nettype wire
